FILE: rtl/circle_rect_coverage_blend_defines.svh
// Assertion macros for the circle and rectangle coverage blender.
// Included by the top level; no other dependencies.
`ifndef CIRCLE_RECT_COVERAGE_BLEND_DEFINES_SVH
`define CIRCLE_RECT_COVERAGE_BLEND_DEFINES_SVH

`ifndef SYNTHESIS
`define CRCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CRCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRCB_ASSERT_IMP(lbl, ante, cons, msg)
`define CRCB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/crcb_pkg.sv
// Constants shared by the circle and rectangle coverage blender:
// register indexes, shape and blend codes, reset values. No dependencies.
package crcb_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegShapeKind  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBlendMode  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginX    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOriginY    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegExtentA    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegExtentB    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRingWidth  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegPaintColor = 3'd7;

  localparam logic [1:0] ShapeFillCircle = 2'd0;
  localparam logic [1:0] ShapeRing       = 2'd1;
  localparam logic [1:0] ShapeFillRect   = 2'd2;

  localparam logic BlendOverlay  = 1'b0;
  localparam logic BlendAlphaMix = 1'b1;

  localparam int unsigned OriginW = 12;
  localparam int unsigned ExtAW   = 15;
  localparam int unsigned ExtBW   = 12;
  localparam int unsigned RingW   = 10;

  localparam logic [1:0]          RstShapeKind  = ShapeFillCircle;
  localparam logic                RstBlendMode  = BlendAlphaMix;
  localparam logic [RingW-1:0]    RstRingWidth  = 10'd16;
  localparam logic [31:0]         RstPaintColor = 32'hFF00_0000;

endpackage

FILE: rtl/circle_rect_coverage_blend.sv
// Circle, ring and rectangle coverage test with paint blend, five-stage pipeline.
// Depends on crcb_pkg and circle_rect_coverage_blend_defines.svh.
//
// Usage: pixel requests enter on the s_axis channel (column, row and the
// current RGBA value) and leave on the m_axis channel as the resulting RGBA
// value, with tuser set when the configured shape covered the pixel.
// Configuration is written over the cfg channel (index and data), which is
// always ready; write it only while no request is in flight.
// Throughput is one pixel per clock while m_axis is ready: stages are dx/dy, squares and radius
// thresholds, distance compare, channel products, divide by 255 and select.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so bubbles close up while the receiver stalls and input
// is refused only when all five stages hold requests and m_axis is stalled.
// Reset clears all valid bits and sets the registers to their defaults:
// filled circle, alpha mix, origin 0, extents 0, ring width one pixel,
// paint color opaque black.
`include "circle_rect_coverage_blend_defines.svh"

module circle_rect_coverage_blend #(
  parameter int unsigned COORD_BITS = 10,
  localparam int unsigned STDataW = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Fields from bit 0: pixel_col, pixel_row, dst_red, dst_green, dst_blue, dst_alpha.
  input  logic [STDataW-1:0]           s_axis_tdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0: out_red, out_green, out_blue, out_alpha.
  output logic [31:0]                  m_axis_tdata_o,
  // Fields from bit 0: covered.
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [crcb_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [31:0]                  cfg_data_i
);

  localparam int unsigned NStages = 5;
  localparam int unsigned CoordMax = (COORD_BITS > crcb_pkg::OriginW) ?
                                     COORD_BITS : crcb_pkg::OriginW;
  localparam int unsigned DxW  = CoordMax + 2;
  localparam int unsigned SqW  = 2 * DxW - 2;
  localparam int unsigned D2W  = SqW + 1;
  localparam int unsigned ThW  = (D2W > 24) ? D2W : 24;
  localparam int unsigned CmpW = ((DxW > crcb_pkg::ExtAW) ? DxW : crcb_pkg::ExtAW) + 1;

  // Configuration registers.
  logic [1:0]                     shape_kind_q;
  logic                           blend_mode_q;
  logic [crcb_pkg::OriginW-1:0]   origin_x_q, origin_y_q;
  logic [crcb_pkg::ExtAW-1:0]     extent_a_q;
  logic [crcb_pkg::ExtBW-1:0]     extent_b_q;
  logic [crcb_pkg::RingW-1:0]     ring_width_q;
  logic [31:0]                    paint_color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_kind_q  <= crcb_pkg::RstShapeKind;
      blend_mode_q  <= crcb_pkg::RstBlendMode;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      extent_a_q    <= '0;
      extent_b_q    <= '0;
      ring_width_q  <= crcb_pkg::RstRingWidth;
      paint_color_q <= crcb_pkg::RstPaintColor;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        crcb_pkg::RegShapeKind:  shape_kind_q  <= cfg_data_i[1:0];
        crcb_pkg::RegBlendMode:  blend_mode_q  <= cfg_data_i[0];
        crcb_pkg::RegOriginX:    origin_x_q    <= cfg_data_i[crcb_pkg::OriginW-1:0];
        crcb_pkg::RegOriginY:    origin_y_q    <= cfg_data_i[crcb_pkg::OriginW-1:0];
        crcb_pkg::RegExtentA:    extent_a_q    <= cfg_data_i[crcb_pkg::ExtAW-1:0];
        crcb_pkg::RegExtentB:    extent_b_q    <= cfg_data_i[crcb_pkg::ExtBW-1:0];
        crcb_pkg::RegRingWidth:  ring_width_q  <= cfg_data_i[crcb_pkg::RingW-1:0];
        crcb_pkg::RegPaintColor: paint_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and per-stage advance enables.
  logic [NStages-1:0] v_q, v_d, en;

  always_comb begin
    en[NStages-1] = !v_q[NStages-1] || m_axis_tready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? s_axis_tvalid_i : v_q[0];
    for (int k = 1; k < NStages; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage 1: offsets from the origin and the ring radii (in 1/32 pixel).
  logic [COORD_BITS-1:0]  in_col, in_row;
  logic [31:0]            in_rgba;
  logic signed [DxW-1:0]  dx_d, dy_d;
  logic [15:0]            two_r;
  logic [15:0]            inner_d;
  logic [16:0]            outer_d;

  assign in_col  = s_axis_tdata_i[COORD_BITS-1:0];
  assign in_row  = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign in_rgba = s_axis_tdata_i[2*COORD_BITS+31:2*COORD_BITS];

  always_comb begin
    dx_d  = signed'({{(DxW-COORD_BITS){1'b0}}, in_col})
          - signed'({{(DxW-crcb_pkg::OriginW){origin_x_q[crcb_pkg::OriginW-1]}}, origin_x_q});
    dy_d  = signed'({{(DxW-COORD_BITS){1'b0}}, in_row})
          - signed'({{(DxW-crcb_pkg::OriginW){origin_y_q[crcb_pkg::OriginW-1]}}, origin_y_q});
    two_r = {extent_a_q, 1'b0};
    // A ring thicker than its diameter reaches all the way to the center.
    if ({6'd0, ring_width_q} > two_r) begin
      inner_d = '0;
    end else begin
      inner_d = two_r - {6'd0, ring_width_q};
    end
    outer_d = {1'b0, two_r} + {7'd0, ring_width_q};
  end

  logic signed [DxW-1:0] dx_q, dy_q;
  logic [15:0]           inner_q;
  logic [16:0]           outer_q;
  logic [31:0]           rgba1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      inner_q <= inner_d;
      outer_q <= outer_d;
      rgba1_q <= in_rgba;
    end
  end

  // Stage 2: squares, radius thresholds and the rectangle test.
  logic signed [2*DxW-1:0] sqx_full, sqy_full;
  logic [29:0]             rr_full;
  logic [31:0]             in2_full;
  logic [33:0]             out2_full;
  logic [CmpW-1:0]         dx_ext, dy_ext;
  logic                    rect_hit_d;

  always_comb begin
    sqx_full  = dx_q * dx_q;
    sqy_full  = dy_q * dy_q;
    rr_full   = {15'd0, extent_a_q} * {15'd0, extent_a_q};
    in2_full  = {16'd0, inner_q} * {16'd0, inner_q};
    out2_full = {17'd0, outer_q} * {17'd0, outer_q};
    dx_ext    = {{(CmpW-DxW){1'b0}}, dx_q};
    dy_ext    = {{(CmpW-DxW){1'b0}}, dy_q};
    rect_hit_d = !dx_q[DxW-1] && !dy_q[DxW-1]
              && (dx_ext < {{(CmpW-crcb_pkg::ExtAW){1'b0}}, extent_a_q})
              && (dy_ext < {{(CmpW-crcb_pkg::ExtBW){1'b0}}, extent_b_q});
  end

  logic [SqW-1:0] sqx_q, sqy_q;
  logic [21:0]    thr_fill_q, thr_in_q;
  logic [23:0]    thr_out_q;
  logic           rect_hit_q;
  logic [31:0]    rgba2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sqx_q      <= sqx_full[SqW-1:0];
      sqy_q      <= sqy_full[SqW-1:0];
      thr_fill_q <= rr_full[29:8];
      thr_in_q   <= in2_full[31:10];
      thr_out_q  <= out2_full[33:10];
      rect_hit_q <= rect_hit_d;
      rgba2_q    <= rgba1_q;
    end
  end

  // Stage 3: squared distance against the thresholds.
  logic [ThW-1:0] d2;
  logic           cov_d;

  always_comb begin
    d2 = {{(ThW-SqW){1'b0}}, sqx_q} + {{(ThW-SqW){1'b0}}, sqy_q};
    case (shape_kind_q)
      crcb_pkg::ShapeFillCircle: cov_d = d2 <= {{(ThW-22){1'b0}}, thr_fill_q};
      crcb_pkg::ShapeRing:       cov_d = (d2 >= {{(ThW-22){1'b0}}, thr_in_q})
                                      && (d2 <= {{(ThW-24){1'b0}}, thr_out_q});
      crcb_pkg::ShapeFillRect:   cov_d = rect_hit_q;
      default:                   cov_d = 1'b0;
    endcase
  end

  logic        cov3_q;
  logic [31:0] rgba3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      cov3_q  <= cov_d;
      rgba3_q <= rgba2_q;
    end
  end

  // Stage 4: mix numerators dst*(255-a) + src*a for red, green and blue.
  logic [7:0]  src_a, inv_a;
  logic [15:0] mix_d [3];

  assign src_a = paint_color_q[31:24];
  assign inv_a = 8'd255 - src_a;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix_d[c] = {8'd0, rgba3_q[8*c +: 8]} * {8'd0, inv_a}
               + {8'd0, paint_color_q[8*c +: 8]} * {8'd0, src_a};
    end
  end

  logic        cov4_q;
  logic [31:0] rgba4_q;
  logic [15:0] mix_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      cov4_q  <= cov3_q;
      rgba4_q <= rgba3_q;
      mix_q   <= mix_d;
    end
  end

  // Stage 5: divide by 255 (exact for every numerator up to 255 * 255) and
  // pick the result.
  logic [16:0] quo [3];
  logic [31:0] res_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo[c] = {1'b0, mix_q[c]} + 17'd1 + {9'd0, mix_q[c][15:8]};
    end
    if (!cov4_q) begin
      res_d = rgba4_q;
    end else if (blend_mode_q == crcb_pkg::BlendOverlay) begin
      res_d = paint_color_q;
    end else begin
      res_d = {8'hFF, quo[2][15:8], quo[1][15:8], quo[0][15:8]};
    end
  end

  logic [31:0] out_rgba_q;
  logic        out_cov_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_rgba_q <= res_d;
      out_cov_q  <= cov4_q;
    end
  end

  assign m_axis_tdata_o  = out_rgba_q;
  assign m_axis_tuser_o  = out_cov_q;
  assign m_axis_tvalid_o = v_q[NStages-1];

  `CRCB_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready_o, &v_q, "input refused too early")
  `CRCB_ASSERT_NXT(a_accept_lands, s_axis_tvalid_i && s_axis_tready_o, v_q[0], "request lost")
  `CRCB_ASSERT_IMP(a_full_rate, m_axis_tready_i, s_axis_tready_o, "input stalled while draining")

endmodule

FILE: sim/tb_circle_rect_coverage_blend.sv
// Self-checking testbench for circle_rect_coverage_blend: directed and random pixel
// requests under many shape settings, checked against a behavioral predictor.
// Depends on crcb_pkg and the circle_rect_coverage_blend top level.
module tb_circle_rect_coverage_blend;

  localparam int unsigned CoordBits  = 10;
  localparam int unsigned PixDataW   = ((2 * CoordBits + 32 + 7) / 8) * 8;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [1:0]  ShapeUnused = 2'd3;

  typedef struct packed {
    logic [7:0]           alpha;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col;
  } pixel_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       covered;
  } pixel_res_t;

  typedef struct {
    logic [1:0]                   shape;
    logic                         blend;
    logic [crcb_pkg::OriginW-1:0] ox;
    logic [crcb_pkg::OriginW-1:0] oy;
    logic [crcb_pkg::ExtAW-1:0]   ext_a;
    logic [crcb_pkg::ExtBW-1:0]   ext_b;
    logic [crcb_pkg::RingW-1:0]   ring_w;
    logic [31:0]                  paint;
  } shape_cfg_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic [PixDataW-1:0]          s_tdata = '0;
  logic                         s_tvalid = 1'b0;
  logic                         m_tready = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [crcb_pkg::CfgIdxW-1:0] cfg_addr = '0;
  logic [31:0]                  cfg_data = '0;

  logic                s_axis_tready_o;
  logic [31:0]         m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tvalid_o;
  logic                cfg_ready_o;

  circle_rect_coverage_blend #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  shape_cfg_t shade_cfg;
  pixel_req_t pixel_q[$];
  pixel_res_t shade_expect_q[$];
  pixel_res_t want;

  int errors = 0;
  int n_results = 0;
  int n_covered = 0;
  int n_phases = 0;
  int n_writes = 0;
  int burst_left;
  int gap_left;
  int rx_mode;
  int rx_mode_left;
  int hold_left;
  bit hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  function automatic logic [7:0] mix_channel(logic [7:0] dst, logic [7:0] src, logic [7:0] a);
    int unsigned acc;
    acc = int'(dst) * (255 - int'(a)) + int'(src) * int'(a);
    return 8'(acc / 255);
  endfunction

  function automatic pixel_res_t shade_pixel(pixel_req_t p, shape_cfg_t c);
    longint ox, oy, col, row, dx, dy, d2, rad, rw, inner, outer;
    logic hit;
    pixel_res_t res;
    ox = $signed(c.ox);
    oy = $signed(c.oy);
    col = longint'(p.col);
    row = longint'(p.row);
    dx = col - ox;
    dy = row - oy;
    d2 = dx * dx + dy * dy;
    rad = longint'(c.ext_a);
    rw = longint'(c.ring_w);
    case (c.shape)
      crcb_pkg::ShapeFillCircle: hit = (d2 <= ((rad * rad) >>> 8));
      crcb_pkg::ShapeRing: begin
        // A line wider than the diameter leaves no hole in the middle.
        inner = 2 * rad - rw;
        if (inner < 0) inner = 0;
        outer = 2 * rad + rw;
        hit = (((inner * inner) >>> 10) <= d2) && (d2 <= ((outer * outer) >>> 10));
      end
      crcb_pkg::ShapeFillRect: begin
        hit = (ox <= col) && (col < ox + rad) &&
              (oy <= row) && (row < oy + longint'(c.ext_b));
      end
      default: hit = 1'b0;
    endcase
    res.covered = hit;
    if (!hit) begin
      res.red = p.red;
      res.green = p.green;
      res.blue = p.blue;
      res.alpha = p.alpha;
    end else if (c.blend == crcb_pkg::BlendOverlay) begin
      res.red = c.paint[7:0];
      res.green = c.paint[15:8];
      res.blue = c.paint[23:16];
      res.alpha = c.paint[31:24];
    end else begin
      res.red = mix_channel(p.red, c.paint[7:0], c.paint[31:24]);
      res.green = mix_channel(p.green, c.paint[15:8], c.paint[31:24]);
      res.blue = mix_channel(p.blue, c.paint[23:16], c.paint[31:24]);
      res.alpha = 8'hFF;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Pixel sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        shade_expect_q = {shade_expect_q,
                          shade_pixel(pixel_req_t'(s_tdata[$bits(pixel_req_t)-1:0]),
                                      shade_cfg)};
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_tdata <= PixDataW'(pixel_q.pop_front());
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: checks each result and stalls in changing modes, with one
  // long hold-off so the pipeline fills and pushes back on the sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_mode <= 0;
      rx_mode_left <= 0;
      hold_left <= 0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        if (shade_expect_q.size() == 0) begin
          $error("result with no pixel request pending: tdata %h tuser %b",
                 m_axis_tdata_o, m_axis_tuser_o);
          errors++;
        end else begin
          want = shade_expect_q.pop_front();
          check_field("out_red", want.red, m_axis_tdata_o[7:0]);
          check_field("out_green", want.green, m_axis_tdata_o[15:8]);
          check_field("out_blue", want.blue, m_axis_tdata_o[23:16]);
          check_field("out_alpha", want.alpha, m_axis_tdata_o[31:24]);
          check_field("covered", 8'(want.covered), 8'(m_axis_tuser_o));
          n_results++;
          if (want.covered) n_covered++;
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!hold_done && n_results >= 500 && pixel_q.size() > 20) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_mode_left <= $urandom_range(20, 80);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending.",
               cycle_cnt, shade_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Leaves valid high so that back-to-back writes need no extra assignment.
  task automatic write_reg(input logic [crcb_pkg::CfgIdxW-1:0] idx, input logic [31:0] val,
                           input int unsigned width);
    logic [31:0] word;
    word = val;
    // Bits above the register width must be ignored.
    if (width < 32 && $urandom_range(0, 2) == 0) word = word | ($urandom << width);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      crcb_pkg::RegShapeKind:  shade_cfg.shape = word[1:0];
      crcb_pkg::RegBlendMode:  shade_cfg.blend = word[0];
      crcb_pkg::RegOriginX:    shade_cfg.ox = word[crcb_pkg::OriginW-1:0];
      crcb_pkg::RegOriginY:    shade_cfg.oy = word[crcb_pkg::OriginW-1:0];
      crcb_pkg::RegExtentA:    shade_cfg.ext_a = word[crcb_pkg::ExtAW-1:0];
      crcb_pkg::RegExtentB:    shade_cfg.ext_b = word[crcb_pkg::ExtBW-1:0];
      crcb_pkg::RegRingWidth:  shade_cfg.ring_w = word[crcb_pkg::RingW-1:0];
      crcb_pkg::RegPaintColor: shade_cfg.paint = word;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_shape(input logic [1:0] shape, input logic blend, input int ox,
                           input int oy, input int ea, input int eb, input int rw,
                           input logic [31:0] paint);
    write_reg(crcb_pkg::RegShapeKind, 32'(shape), 2);
    write_reg(crcb_pkg::RegBlendMode, 32'(blend), 1);
    write_reg(crcb_pkg::RegOriginX, 32'(ox), crcb_pkg::OriginW);
    write_reg(crcb_pkg::RegOriginY, 32'(oy), crcb_pkg::OriginW);
    write_reg(crcb_pkg::RegExtentA, 32'(ea), crcb_pkg::ExtAW);
    write_reg(crcb_pkg::RegExtentB, 32'(eb), crcb_pkg::ExtBW);
    write_reg(crcb_pkg::RegRingWidth, 32'(rw), crcb_pkg::RingW);
    write_reg(crcb_pkg::RegPaintColor, paint, 32);
    cfg_valid <= 1'b0;
    n_phases++;
  endtask

  task automatic add_pixel(input int col, input int row, input logic [31:0] rgba);
    pixel_req_t p;
    p.col = CoordBits'(col);
    p.row = CoordBits'(row);
    {p.alpha, p.blue, p.green, p.red} = rgba;
    pixel_q = {pixel_q, p};
  endtask

  // Registers may change only once every request has left the pipeline.
  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid || shade_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    int pick, ox, oy, ea, eb, rw, span, col, row, lim_a, lim_b;
    logic [1:0] shape;
    logic [31:0] paint;
    pick = $urandom_range(0, 10);
    shape = (pick < 4) ? crcb_pkg::ShapeFillCircle : (pick < 7) ? crcb_pkg::ShapeRing :
            (pick < 10) ? crcb_pkg::ShapeFillRect : ShapeUnused;
    ox = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                     : int'($urandom_range(0, 1151)) - 64;
    oy = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                     : int'($urandom_range(0, 1151)) - 64;
    if (shape == crcb_pkg::ShapeFillRect) begin
      ea = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 400);
    end else begin
      ea = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 4800);
    end
    eb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
    rw = $urandom_range(0, 1023);
    paint = $urandom;
    case ($urandom_range(0, 3))
      0: paint[31:24] = 8'h00;
      1: paint[31:24] = 8'hFF;
      default: ;
    endcase
    set_shape(shape, 1'($urandom_range(0, 1)), ox, oy, ea, eb, rw, paint);
    span = (ea + rw) / 16 + 3;
    if (span > 1100) span = 1100;
    lim_a = (ea > 1100) ? 1100 : ea;
    lim_b = (eb > 1100) ? 1100 : eb;
    repeat (n) begin
      // Unless the shape code is unused, most pixels land in a box around the shape so both outcomes are common.
      if (shape == ShapeUnused || $urandom_range(0, 9) >= 7) begin
        col = $urandom_range(0, 1023);
        row = $urandom_range(0, 1023);
      end else if (shape == crcb_pkg::ShapeFillRect) begin
        col = ox - 3 + int'($urandom_range(0, lim_a + 6));
        row = oy - 3 + int'($urandom_range(0, lim_b + 6));
      end else begin
        col = ox - span + int'($urandom_range(0, 2 * span));
        row = oy - span + int'($urandom_range(0, 2 * span));
      end
      add_pixel(col, row, $urandom);
    end
    drain();
  endtask

  initial begin
    shade_cfg.shape = crcb_pkg::RstShapeKind;
    shade_cfg.blend = crcb_pkg::RstBlendMode;
    shade_cfg.ox = '0;
    shade_cfg.oy = '0;
    shade_cfg.ext_a = '0;
    shade_cfg.ext_b = '0;
    shade_cfg.ring_w = crcb_pkg::RstRingWidth;
    shade_cfg.paint = crcb_pkg::RstPaintColor;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A circle of radius zero covers only its center.
    set_shape(crcb_pkg::ShapeFillCircle, crcb_pkg::BlendAlphaMix, 0, 0, 0, 0, 0,
              32'hFF00_0000);
    add_pixel(0, 0, 32'hFFFF_FFFF);
    add_pixel(1, 0, 32'h0000_0000);
    drain();
    // Radius of exactly 100 pixels, half-transparent paint.
    set_shape(crcb_pkg::ShapeFillCircle, crcb_pkg::BlendAlphaMix, 512, 512, 1600, 0, 0,
              32'h8040_C020);
    add_pixel(512, 512, 32'h1234_5678);
    add_pixel(612, 512, 32'hFFFF_FFFF);
    add_pixel(613, 512, 32'h0000_0000);
    add_pixel(1023, 1023, 32'hA5A5_5A5A);
    drain();
    // Two-pixel ring at radius 50: inner edge 49, outer edge 51.
    set_shape(crcb_pkg::ShapeRing, crcb_pkg::BlendOverlay, 300, 300, 800, 0, 32,
              32'h5AA5_3CC3);
    for (int d = 48; d <= 52; d++) add_pixel(300 + d, 300, $urandom);
    drain();
    // Ring thicker than its diameter fills in to the outer bound.
    set_shape(crcb_pkg::ShapeRing, crcb_pkg::BlendOverlay, 0, 0, 8, 0, 1023, 32'h0000_0000);
    add_pixel(0, 0, 32'hFFFF_FFFF);
    add_pixel(32, 0, 32'h8080_8080);
    add_pixel(0, 33, 32'h0102_0304);
    drain();
    set_shape(ShapeUnused, crcb_pkg::BlendOverlay, 0, 0, 32767, 4095, 1023, 32'hFFFF_FFFF);
    add_pixel(0, 0, 32'h0000_0000);
    add_pixel(5, 5, 32'hDEAD_BEEF);
    drain();
    // Fully transparent paint leaves color channels as they were.
    set_shape(crcb_pkg::ShapeFillRect, crcb_pkg::BlendAlphaMix, 100, 200, 10, 5, 0,
              32'h00FF_FFFF);
    add_pixel(100, 200, 32'h1122_3344);
    add_pixel(109, 204, 32'hFFFF_FFFF);
    add_pixel(110, 204, 32'h5566_7788);
    add_pixel(109, 205, 32'h99AA_BBCC);
    add_pixel(99, 200, 32'h0000_0000);
    drain();
    set_shape(crcb_pkg::ShapeFillRect, crcb_pkg::BlendOverlay, -2048, -2048, 32767, 4095, 512,
              32'hFFFF_FFFF);
    add_pixel(1023, 1023, 32'h0000_0000);
    add_pixel(0, 0, 32'h7F7F_7F7F);
    drain();
    set_shape(crcb_pkg::ShapeFillRect, crcb_pkg::BlendAlphaMix, 10, 10, 0, 5, 0,
              32'hFF12_3456);
    add_pixel(10, 10, 32'hFFFF_FFFF);
    drain();
    set_shape(crcb_pkg::ShapeFillCircle, crcb_pkg::BlendAlphaMix, 2047, -2048, 32767, 2048,
              1023, 32'hFFFF_FFFF);
    add_pixel(1023, 0, 32'h0000_0000);
    add_pixel(1023, 1023, 32'h8000_0001);
    drain();

    for (int ph = 0; ph < 14; ph++) random_phase($urandom_range(90, 126));

    repeat (10) @(posedge clk_i);
    $display("Checked %0d pixel results over %0d shape settings, %0d of them covered.",
             n_results, n_phases, n_covered);
    $display("Used %0d register writes, all shape codes, both blend modes, one long stall.",
             n_writes);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
